// File: design/stbs_pkg.sv
// Shared types and constants for the sorted-table binary search unit.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package stbs_pkg;

	// Fixed field widths of the request and result items
	localparam int MODE_W = 4;
	localparam int KEY_W  = 32;
	localparam int POS_W  = 12;
	localparam int POS2_W = 11;
	localparam int CNT_W  = 11;

	// Request modes
	localparam logic [MODE_W-1:0] MODE_LOAD   = 4'd0;
	localparam logic [MODE_W-1:0] MODE_EXACT  = 4'd1;
	localparam logic [MODE_W-1:0] MODE_LOWER  = 4'd2;
	localparam logic [MODE_W-1:0] MODE_UPPER  = 4'd3;
	localparam logic [MODE_W-1:0] MODE_FIRST  = 4'd4;
	localparam logic [MODE_W-1:0] MODE_LAST   = 4'd5;
	localparam logic [MODE_W-1:0] MODE_RANGE  = 4'd6;
	localparam logic [MODE_W-1:0] MODE_FLOOR  = 4'd7;
	localparam logic [MODE_W-1:0] MODE_CEIL   = 4'd8;
	localparam logic [MODE_W-1:0] MODE_COUNT  = 4'd9;
	localparam logic [MODE_W-1:0] MODE_SINGLE = 4'd10;

	// Search pass variants run by the datapath
	typedef enum logic [2:0] {
		PK_EXACT,
		PK_LB,
		PK_UB,
		PK_FIRST,
		PK_LAST,
		PK_FLOOR,
		PK_CEIL,
		PK_SINGLE
	} kind_t;

	// Table address source for a read
	typedef enum logic [1:0] {
		ADDR_MID,
		ADDR_MID1,
		ADDR_LO
	} addr_sel_t;

	// Controller to datapath commands
	typedef struct packed {
		kind_t     kind;
		logic      use_high;
		logic      accept;
		logic      load;
		logic      init;
		logic      rd;
		addr_sel_t addr_sel;
		logic      upd;
		logic      pair;
		logic      fetch_done;
		logic      pass_end;
		logic      out_load;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic go;    // loop condition of the current pass holds
		logic hit;   // probed key equals the target
		logic past;  // single-element search ended past the last key
	} status_t;

endpackage

`default_nettype wire

// File: design/sorted_table_binary_search_unit.sv
// Sorted-table binary search unit. Load requests (mode 0) append one signed
// 32-bit key to the table (first_of_table restarts it; keys past TABLE_SIZE
// are dropped) and give no result. Every query request gives one result; the
// table is expected to be loaded in ascending order. The unit works on one
// request at a time: a load writes the key in its own state; a query runs a
// setup, then probes (one read of the single-port key RAM, one compare),
// floor(log2(n))+1 probes at most for n keys, then ends the loop, closes the
// pass and hands off the result (an exact search that hits skips the loop
// end). The single-element query makes two reads per probe plus a final
// read when it ends inside the table; both-occurrence and count queries add a
// second pass with its own setup, its probes and its closing. A finished
// result sits in an output register, so the next request is taken while it
// waits.
// Depends on stbs_pkg, stbs_ctrl and stbs_dp.
`default_nettype none

module sorted_table_binary_search_unit #(
	parameter int TABLE_SIZE = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic        [stbs_pkg::MODE_W-1:0]  mode,
	input  wire logic signed [stbs_pkg::KEY_W-1:0]   key,
	input  wire logic signed [stbs_pkg::KEY_W-1:0]   high_key,
	input  wire logic                                first_of_table,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed      [stbs_pkg::POS_W-1:0]   position,
	output logic signed      [stbs_pkg::POS2_W-1:0]  second_position,
	output logic signed      [stbs_pkg::KEY_W-1:0]   value,
	output logic                                     found,
	output logic             [stbs_pkg::CNT_W-1:0]   count
);

	import stbs_pkg::*;

	cmd_t    cmd;
	status_t st;

	stbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd),
		.st       (st)
	);

	stbs_dp #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.mode           (mode),
		.key            (key),
		.high_key       (high_key),
		.first_of_table (first_of_table),
		.position       (position),
		.second_position(second_position),
		.value          (value),
		.found          (found),
		.count          (count)
	);

endmodule

`default_nettype wire

// File: design/stbs_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One access per cycle: write, or registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

// File: design/stbs_dp.sv
// Datapath of the search unit: key table, search bounds, pass results and
// the result register. Depends on stbs_pkg and stbs_ram.
`default_nettype none

module stbs_dp #(
	parameter int TABLE_SIZE = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire stbs_pkg::cmd_t                      cmd,
	output stbs_pkg::status_t                        st,
	input  wire logic        [stbs_pkg::MODE_W-1:0]  mode,
	input  wire logic signed [stbs_pkg::KEY_W-1:0]   key,
	input  wire logic signed [stbs_pkg::KEY_W-1:0]   high_key,
	input  wire logic                                first_of_table,
	output logic signed      [stbs_pkg::POS_W-1:0]   position,
	output logic signed      [stbs_pkg::POS2_W-1:0]  second_position,
	output logic signed      [stbs_pkg::KEY_W-1:0]   value,
	output logic                                     found,
	output logic             [stbs_pkg::CNT_W-1:0]   count
);

	import stbs_pkg::*;

	localparam int CW = $clog2(TABLE_SIZE + 1);  // key count width
	localparam int SW = CW + 1;                  // signed index width
	localparam int AW = $clog2(TABLE_SIZE);      // table address width

	// Latched request
	logic        [MODE_W-1:0] mode_q;
	logic signed [KEY_W-1:0]  key_q;
	logic signed [KEY_W-1:0]  high_q;
	logic                     first_q;

	// Table fill and search state
	logic        [CW-1:0]     count_q;
	logic signed [SW-1:0]     lo_q;
	logic signed [SW-1:0]     hi_q;
	logic signed [SW-1:0]     res_q;
	logic signed [SW-1:0]     save_q;
	logic signed [KEY_W-1:0]  val_q;
	logic                     ok_q;
	logic signed [KEY_W-1:0]  k0_q;

	logic signed [SW-1:0]     count_s;
	logic signed [SW-1:0]     diff;
	logic signed [SW-1:0]     mid;
	logic signed [SW-1:0]     mid_sel;
	logic signed [SW-1:0]     mid_p1;
	logic signed [SW-1:0]     mid_p2;
	logic signed [SW-1:0]     mid_m1;
	logic signed [SW-1:0]     rd_idx;
	logic signed [SW-1:0]     cnt_diff;
	logic signed [KEY_W-1:0]  tgt;
	logic signed [KEY_W-1:0]  rdata;
	logic        [CW-1:0]     load_base;
	logic                     can_wr;
	logic                     ram_we;
	logic        [AW-1:0]     ram_addr;
	logic                     bound_kind;

	logic signed [POS_W-1:0]  position_d;
	logic signed [POS2_W-1:0] second_d;
	logic signed [KEY_W-1:0]  value_d;
	logic                     found_d;
	logic        [CNT_W-1:0]  count_d;

	assign count_s    = signed'({1'b0, count_q});
	assign tgt        = cmd.use_high ? high_q : key_q;
	assign bound_kind = (cmd.kind == PK_LB) || (cmd.kind == PK_UB);

	// Midpoint lo + (hi - lo) / 2, forced even for the pair-parity search
	assign diff    = hi_q - lo_q;
	assign mid     = lo_q + (diff >>> 1);
	assign mid_sel = (cmd.kind == PK_SINGLE) ? {mid[SW-1:1], 1'b0} : mid;
	assign mid_p1  = mid_sel + SW'(1);
	assign mid_p2  = mid_sel + SW'(2);
	assign mid_m1  = mid_sel - SW'(1);

	// Loop condition, exact hit and end-of-table status
	always_comb begin
		st.go   = (bound_kind || cmd.kind == PK_SINGLE) ? (lo_q < hi_q) : (lo_q <= hi_q);
		st.hit  = (rdata == tgt);
		st.past = (lo_q >= count_s);
	end

	// Load slot: restart empties the table first, a full table drops the key
	assign load_base = first_q ? '0 : count_q;
	assign can_wr    = load_base < CW'(TABLE_SIZE);
	assign ram_we    = cmd.load && can_wr;

	// Table address
	always_comb begin
		case (cmd.addr_sel)
			ADDR_MID:  rd_idx = mid_sel;
			ADDR_MID1: rd_idx = mid_p1;
			ADDR_LO:   rd_idx = lo_q;
			default:   rd_idx = mid_sel;
		endcase
		ram_addr = ram_we ? load_base[AW-1:0] : rd_idx[AW-1:0];
	end

	stbs_ram #(
		.WIDTH(KEY_W),
		.DEPTH(TABLE_SIZE)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(key_q),
		.rdata(rdata)
	);

	// Key count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.load) begin
			count_q <= can_wr ? load_base + CW'(1) : load_base;
		end
	end

	// Request latch and search registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q  <= mode;
			key_q   <= key;
			high_q  <= high_key;
			first_q <= first_of_table;
		end
		if (cmd.init) begin
			lo_q  <= '0;
			hi_q  <= bound_kind ? count_s : count_s - SW'(1);
			res_q <= '1;
			val_q <= '1;
			ok_q  <= 1'b0;
		end
		// Probe update on the key read at the midpoint
		if (cmd.upd) begin
			case (cmd.kind)
				PK_EXACT: begin
					if (rdata == tgt) begin
						res_q <= mid_sel;
					end else if (rdata < tgt) begin
						lo_q <= mid_p1;
					end else begin
						hi_q <= mid_m1;
					end
				end
				PK_LB: begin
					if (rdata < tgt) lo_q <= mid_p1;
					else hi_q <= mid_sel;
				end
				PK_UB: begin
					if (rdata <= tgt) lo_q <= mid_p1;
					else hi_q <= mid_sel;
				end
				PK_FIRST: begin
					if (rdata == tgt) begin
						res_q <= mid_sel;
						hi_q  <= mid_m1;
					end else if (rdata < tgt) begin
						lo_q <= mid_p1;
					end else begin
						hi_q <= mid_m1;
					end
				end
				PK_LAST: begin
					if (rdata == tgt) begin
						res_q <= mid_sel;
						lo_q  <= mid_p1;
					end else if (rdata < tgt) begin
						lo_q <= mid_p1;
					end else begin
						hi_q <= mid_m1;
					end
				end
				PK_FLOOR: begin
					if (rdata <= tgt) begin
						val_q <= rdata;
						ok_q  <= 1'b1;
						lo_q  <= mid_p1;
					end else begin
						hi_q <= mid_m1;
					end
				end
				PK_CEIL: begin
					if (rdata >= tgt) begin
						val_q <= rdata;
						ok_q  <= 1'b1;
						hi_q  <= mid_m1;
					end else begin
						lo_q <= mid_p1;
					end
				end
				PK_SINGLE: begin
					k0_q <= rdata;
				end
				default: begin
					k0_q <= rdata;
				end
			endcase
		end
		// Pair check of the single-element search
		if (cmd.pair) begin
			if (k0_q == rdata) lo_q <= mid_p2;
			else hi_q <= mid_sel;
		end
		if (cmd.fetch_done) begin
			val_q <= rdata;
			ok_q  <= 1'b1;
		end
		if (cmd.pass_end) begin
			save_q <= bound_kind ? lo_q : res_q;
		end
		if (cmd.out_load) begin
			position        <= position_d;
			second_position <= second_d;
			value           <= value_d;
			found           <= found_d;
			count           <= count_d;
		end
	end

	// Result formatting per mode; count is upper bound minus lower bound
	assign cnt_diff = save_q - lo_q;

	always_comb begin
		position_d = '0;
		second_d   = '0;
		value_d    = '0;
		found_d    = 1'b0;
		count_d    = '0;
		case (mode_q)
			MODE_EXACT, MODE_FIRST, MODE_LAST: begin
				position_d = POS_W'(res_q);
				found_d    = !res_q[SW-1];
			end
			MODE_LOWER, MODE_UPPER: begin
				position_d = POS_W'(lo_q);
				found_d    = lo_q < count_s;
			end
			MODE_RANGE: begin
				position_d = POS_W'(save_q);
				second_d   = POS2_W'(res_q);
				found_d    = !save_q[SW-1];
			end
			MODE_FLOOR, MODE_CEIL, MODE_SINGLE: begin
				value_d = val_q;
				found_d = ok_q;
			end
			MODE_COUNT: begin
				count_d = cnt_diff[SW-1] ? '0 : CNT_W'(cnt_diff);
				found_d = 1'b1;
			end
			default: begin
				found_d = 1'b0;
			end
		endcase
	end

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_SIZE))
		else $error("key count beyond table size");

	a_read_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> (rd_idx >= 0 && rd_idx < count_s))
		else $error("table read outside the loaded keys");

	a_count_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && mode_q == MODE_COUNT |=> found)
		else $error("count result without found flag");

endmodule

`default_nettype wire

// File: design/stbs_ctrl.sv
// Controller of the search unit: request decode, pass sequencing, probe
// loop and result handoff. Depends on stbs_pkg.
`default_nettype none

module stbs_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [stbs_pkg::MODE_W-1:0]   mode,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output stbs_pkg::cmd_t                     cmd,
	input  wire stbs_pkg::status_t             st
);

	import stbs_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_LOAD   = 10'b00_0000_0010,
		S_INIT   = 10'b00_0000_0100,
		S_PROBE  = 10'b00_0000_1000,
		S_CMP    = 10'b00_0001_0000,
		S_PAIR   = 10'b00_0010_0000,
		S_FETCH  = 10'b00_0100_0000,
		S_FETCHD = 10'b00_1000_0000,
		S_END    = 10'b01_0000_0000,
		S_DONE   = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;
	kind_t  kind_q, kind_d, second_q, second_d;
	logic   more_q, more_d;
	logic   high_q, high_d;
	logic   out_valid_q;
	logic   accept;
	logic   is_query;
	kind_t  first_kind;
	kind_t  next_kind;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Decode the first and second pass of a query
	always_comb begin
		is_query   = 1'b1;
		first_kind = PK_EXACT;
		next_kind  = PK_EXACT;
		case (mode)
			MODE_EXACT:  first_kind = PK_EXACT;
			MODE_LOWER:  first_kind = PK_LB;
			MODE_UPPER:  first_kind = PK_UB;
			MODE_FIRST:  first_kind = PK_FIRST;
			MODE_LAST:   first_kind = PK_LAST;
			MODE_RANGE: begin
				first_kind = PK_FIRST;
				next_kind  = PK_LAST;
			end
			MODE_FLOOR:  first_kind = PK_FLOOR;
			MODE_CEIL:   first_kind = PK_CEIL;
			MODE_COUNT: begin
				first_kind = PK_UB;
				next_kind  = PK_LB;
			end
			MODE_SINGLE: first_kind = PK_SINGLE;
			default:     is_query   = 1'b0;
		endcase
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		kind_d   = kind_q;
		second_d = second_q;
		more_d   = more_q;
		high_d   = high_q;

		cmd            = '0;
		cmd.kind       = kind_q;
		cmd.use_high   = high_q;
		cmd.accept     = accept;
		cmd.addr_sel   = ADDR_MID;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					kind_d   = first_kind;
					second_d = next_kind;
					more_d   = (mode == MODE_RANGE) || (mode == MODE_COUNT);
					high_d   = (mode == MODE_COUNT);
					if (mode == MODE_LOAD) state_d = S_LOAD;
					else if (is_query) state_d = S_INIT;
				end
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = S_IDLE;
			end
			S_INIT: begin
				cmd.init = 1'b1;
				state_d  = S_PROBE;
			end
			S_PROBE: begin
				if (st.go) begin
					cmd.rd  = 1'b1;
					state_d = S_CMP;
				end else if (kind_q == PK_SINGLE) begin
					state_d = S_FETCH;
				end else begin
					state_d = S_END;
				end
			end
			S_CMP: begin
				cmd.upd = 1'b1;
				if (kind_q == PK_SINGLE) begin
					cmd.rd       = 1'b1;
					cmd.addr_sel = ADDR_MID1;
					state_d      = S_PAIR;
				end else if (kind_q == PK_EXACT && st.hit) begin
					state_d = S_END;
				end else begin
					state_d = S_PROBE;
				end
			end
			S_PAIR: begin
				cmd.pair = 1'b1;
				state_d  = S_PROBE;
			end
			S_FETCH: begin
				if (st.past) begin
					state_d = S_END;
				end else begin
					cmd.rd       = 1'b1;
					cmd.addr_sel = ADDR_LO;
					state_d      = S_FETCHD;
				end
			end
			S_FETCHD: begin
				cmd.fetch_done = 1'b1;
				state_d        = S_END;
			end
			S_END: begin
				if (more_q) begin
					// keep the first pass result for the second pass
					cmd.pass_end = 1'b1;
					kind_d  = second_q;
					more_d  = 1'b0;
					high_d  = 1'b0;
					state_d = S_INIT;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State, pass sequencing and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= PK_EXACT;
			second_q    <= PK_EXACT;
			more_q      <= 1'b0;
			high_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			kind_q   <= kind_d;
			second_q <= second_d;
			more_q   <= more_d;
			high_q   <= high_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Checks
	a_load_path: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode == MODE_LOAD |=> state_q == S_LOAD)
		else $error("load request did not reach the write state");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the handoff state");

	a_hold_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && out_valid_q && !out_ready |=> state_q == S_DONE)
		else $error("finished result overwrote a pending one");

endmodule

`default_nettype wire

// File: bench/sorted_table_binary_search_unit_test.sv
// Self-checking bench for sorted_table_binary_search_unit: predicts each query result from its
// own copy of the key table and checks results in order under random handshake stalls.
// Depends on stbs_pkg and the unit's RTL only.
`default_nettype none

module sorted_table_binary_search_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import stbs_pkg::*;

	localparam int TABLE_DEPTH = 1024;
	localparam int KEY_MAX = 32'sh7FFF_FFFF;
	localparam int KEY_MIN = 32'sh8000_0000;
	localparam int MAX_GAP = 18;
	localparam int WORK_TARGET = 1725;
	localparam logic [MODE_W-1:0] MODE_UNUSED_LO = MODE_SINGLE + 1'b1;
	localparam logic [MODE_W-1:0] MODE_UNUSED_HI = '1;

	// One result as the unit reports it
	typedef struct {
		logic signed [POS_W-1:0]  position;
		logic signed [POS2_W-1:0] second_position;
		logic signed [KEY_W-1:0]  value;
		logic                     found;
		logic        [CNT_W-1:0]  count;
	} answer_t;

	// Keeps a shadow key table and the answers still owed by the unit
	class search_scoreboard;
		int      key_store[TABLE_DEPTH];
		int      key_total;
		answer_t pending[$];
		int      mismatches, loads, dropped, queries, ignored, checked, peak;

		function int exact_index(int t);
			int lo, hi, mid;
			lo = 0;
			hi = key_total - 1;
			while (lo <= hi) begin
				mid = lo + (hi - lo) / 2;
				if (key_store[mid] == t)
					return mid;
				if (key_store[mid] < t)
					lo = mid + 1;
				else
					hi = mid - 1;
			end
			return -1;
		endfunction

		// strict=0: first key >= t, strict=1: first key > t
		function int bound_index(int t, bit strict);
			int lo, hi, mid;
			lo = 0;
			hi = key_total;
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if (key_store[mid] < t || (strict && key_store[mid] == t))
					lo = mid + 1;
				else
					hi = mid;
			end
			return lo;
		endfunction

		function int occurrence_index(int t, bit want_last);
			int lo, hi, mid, res;
			lo = 0;
			hi = key_total - 1;
			res = -1;
			while (lo <= hi) begin
				mid = lo + (hi - lo) / 2;
				if (key_store[mid] == t) begin
					res = mid;
					if (want_last)
						lo = mid + 1;
					else
						hi = mid - 1;
				end else if (key_store[mid] < t) begin
					lo = mid + 1;
				end else begin
					hi = mid - 1;
				end
			end
			return res;
		endfunction

		// floor (largest key <= t) or ceil (smallest key >= t)
		function bit nearest_key(int t, bit want_ceil, output int v);
			int lo, hi, mid;
			bit ok;
			lo = 0;
			hi = key_total - 1;
			ok = 1'b0;
			v = -1;
			while (lo <= hi) begin
				mid = lo + (hi - lo) / 2;
				if (!want_ceil) begin
					if (key_store[mid] <= t) begin
						v = key_store[mid];
						ok = 1'b1;
						lo = mid + 1;
					end else begin
						hi = mid - 1;
					end
				end else begin
					if (key_store[mid] >= t) begin
						v = key_store[mid];
						ok = 1'b1;
						hi = mid - 1;
					end else begin
						lo = mid + 1;
					end
				end
			end
			return ok;
		endfunction

		// pair-parity search for the one key without a twin
		function bit unpaired_key(output int v);
			int lo, hi, mid;
			v = -1;
			if (key_total == 0)
				return 1'b0;
			lo = 0;
			hi = key_total - 1;
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if (mid % 2 == 1)
					mid--;
				if (key_store[mid] == key_store[mid + 1])
					lo = mid + 2;
				else
					hi = mid;
			end
			if (lo >= key_total)
				return 1'b0;
			v = key_store[lo];
			return 1'b1;
		endfunction

		function void note_request(logic [MODE_W-1:0] m, int k, int hk, bit restart);
			answer_t a;
			int      pos, v;
			if (m == MODE_LOAD) begin
				loads++;
				if (restart)
					key_total = 0;
				if (key_total < TABLE_DEPTH) begin
					key_store[key_total] = k;
					key_total++;
				end else begin
					dropped++;
				end
				if (key_total > peak)
					peak = key_total;
				return;
			end
			if (m > MODE_SINGLE) begin
				ignored++;
				return;
			end
			queries++;
			a.position = '0;
			a.second_position = '0;
			a.value = '0;
			a.found = 1'b0;
			a.count = '0;
			case (m)
				MODE_EXACT: begin
					pos = exact_index(k);
					a.position = POS_W'(pos);
					a.found = pos >= 0;
				end
				MODE_LOWER, MODE_UPPER: begin
					pos = bound_index(k, m == MODE_UPPER);
					a.position = POS_W'(pos);
					a.found = pos < key_total;
				end
				MODE_FIRST, MODE_LAST: begin
					pos = occurrence_index(k, m == MODE_LAST);
					a.position = POS_W'(pos);
					a.found = pos >= 0;
				end
				MODE_RANGE: begin
					pos = occurrence_index(k, 1'b0);
					a.position = POS_W'(pos);
					a.second_position = POS2_W'(occurrence_index(k, 1'b1));
					a.found = pos >= 0;
				end
				MODE_FLOOR, MODE_CEIL: begin
					a.found = nearest_key(k, m == MODE_CEIL, v);
					a.value = v;
				end
				MODE_COUNT: begin
					pos = bound_index(hk, 1'b1) - bound_index(k, 1'b0);
					a.count = (pos < 0) ? '0 : CNT_W'(pos);
					a.found = 1'b1;
				end
				default: begin
					a.found = unpaired_key(v);
					a.value = v;
				end
			endcase
			pending.push_back(a);
		endfunction

		function void report_field(string name, longint want, longint got);
			if (want != got) begin
				mismatches++;
				$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(answer_t got);
			answer_t want;
			if (pending.size() == 0) begin
				mismatches++;
				$display("%0t ns: result with nothing outstanding, expected none, actual position %0d",
					$time, got.position);
				return;
			end
			want = pending.pop_front();
			checked++;
			report_field("position", want.position, got.position);
			report_field("second_position", want.second_position, got.second_position);
			report_field("value", want.value, got.value);
			report_field("found", want.found, got.found);
			report_field("count", want.count, got.count);
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic        [MODE_W-1:0] mode = '0;
	logic signed [KEY_W-1:0]  key = '0;
	logic signed [KEY_W-1:0]  high_key = '0;
	logic                     first_of_table = 1'b0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [POS_W-1:0]  position;
	logic signed [POS2_W-1:0] second_position;
	logic signed [KEY_W-1:0]  value;
	logic                     found;
	logic        [CNT_W-1:0]  count;

	search_scoreboard sb = new;
	bit calm = 0;        // no idling on either side while set
	int work_items = 0;

	sorted_table_binary_search_unit #(
		.TABLE_SIZE(TABLE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.key(key),
		.high_key(high_key),
		.first_of_table(first_of_table),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.position(position),
		.second_position(second_position),
		.value(value),
		.found(found),
		.count(count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the unit hangs
	initial begin
		#10ms;
		$display("FAIL");
		$finish;
	end

	// Send one request; valid stays up across back-to-back requests
	task automatic send_request(logic [MODE_W-1:0] m, int k, int hk, bit restart);
		int gap;
		gap = calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		key <= k;
		high_key <= hk;
		first_of_table <= restart;
		do @(posedge clk); while (!in_ready);
		sb.note_request(m, k, hk, restart);
		if (m <= MODE_SINGLE)
			work_items++;
	endtask

	task automatic load_key(int k, bit restart);
		send_request(MODE_LOAD, k, $urandom, restart);
	endtask

	task automatic send_query(logic [MODE_W-1:0] m, int k, int hk);
		send_request(m, k, hk, 1'($urandom_range(0, 1)));
	endtask

	// Hold off new requests until every owed result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending.size() != 0);
	endtask

	// Search target: mostly a stored key or a neighbor of one
	function automatic int pick_target();
		int r, idx;
		r = $urandom_range(0, 9);
		idx = (sb.key_total > 0) ? $urandom_range(0, sb.key_total - 1) : 0;
		if (sb.key_total > 0 && r < 6)
			return sb.key_store[idx];
		if (sb.key_total > 0 && r < 8)
			return sb.key_store[idx] + ($urandom_range(0, 1) ? 1 : -1);
		if (r == 8) begin
			case ($urandom_range(0, 3))
				0: return KEY_MIN;
				1: return KEY_MAX;
				2: return 0;
				default: return -1;
			endcase
		end
		return $urandom;
	endfunction

	// Upper end of a count range: near the low end, reversed, or anywhere
	function automatic int pick_high(int lo);
		case ($urandom_range(0, 3))
			0, 1: return lo + $urandom_range(0, 40);
			2: return lo - $urandom_range(1, 40);
			default: return $urandom;
		endcase
	endfunction

	// Restart the table with n keys in ascending order
	task automatic fill_sorted(int n, bit wide);
		longint cur;
		int     i;
		cur = wide ? longint'(int'($urandom)) : longint'($urandom_range(0, 200)) - 100;
		for (i = 0; i < n; i++) begin
			load_key(int'(cur), i == 0);
			cur += wide ? $urandom_range(0, 1 << 26) : $urandom_range(0, 3);
			if (cur > KEY_MAX)
				cur = KEY_MAX;
		end
	endtask

	task automatic run_queries(int q);
		int i, k;
		for (i = 0; i < q; i++) begin
			if ($urandom_range(0, 15) == 0) begin
				send_request(MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)),
					$urandom, $urandom, 1'($urandom_range(0, 1)));
			end else begin
				k = pick_target();
				send_query(MODE_W'($urandom_range(MODE_EXACT, MODE_SINGLE)), k, pick_high(k));
			end
		end
	endtask

	// Result side: random stalls, check every accepted result
	initial begin
		answer_t got;
		int      stall;
		wait (arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got.position = position;
			got.second_position = second_position;
			got.value = value;
			got.found = found;
			got.count = count;
			sb.check_result(got);
		end
	end

	// Request side: directed cases, then random table/query phases
	initial begin
		int phase, kind, n, i;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table
		send_query(MODE_EXACT, 0, 0);
		send_query(MODE_LOWER, KEY_MAX, 0);
		send_query(MODE_FLOOR, 0, 0);
		send_query(MODE_CEIL, KEY_MIN, 0);
		send_query(MODE_COUNT, KEY_MIN, KEY_MAX);
		send_query(MODE_SINGLE, 0, 0);
		// small table with extremes and a duplicate
		load_key(KEY_MIN, 1'b1);
		load_key(-5, 1'b0);
		load_key(7, 1'b0);
		load_key(7, 1'b0);
		load_key(KEY_MAX, 1'b0);
		send_query(MODE_EXACT, 7, 0);
		send_query(MODE_LOWER, KEY_MAX, 0);
		send_query(MODE_UPPER, KEY_MAX, 0);
		send_query(MODE_FIRST, 7, 0);
		send_query(MODE_LAST, 7, 0);
		send_query(MODE_RANGE, 7, 0);
		send_query(MODE_FLOOR, -6, 0);
		send_query(MODE_CEIL, 8, 0);
		send_query(MODE_COUNT, KEY_MIN, KEY_MAX);
		send_query(MODE_COUNT, 10, -10);
		send_query(MODE_SINGLE, 0, 0);
		send_request(MODE_UNUSED_HI, KEY_MIN, KEY_MAX, 1'b1);

		phase = 0;
		while (work_items < WORK_TARGET) begin
			calm = ($urandom_range(0, 4) == 0);
			if (phase == 0 || phase == 3 || $urandom_range(0, 5) == 0)
				drain_results();
			if (phase == 3) begin
				// full table, then loads that must be dropped
				fill_sorted(TABLE_DEPTH, 1'b0);
				for (i = 0; i < 6; i++)
					load_key($urandom, 1'b0);
				run_queries(40);
			end else begin
				kind = $urandom_range(0, 19);
				if (kind <= 12) begin
					n = (kind < 11) ? $urandom_range(1, 12) : $urandom_range(13, 60);
					fill_sorted(n, $urandom_range(0, 3) == 0);
				end else if (kind <= 14) begin
					// unsorted contents
					n = $urandom_range(1, 12);
					for (i = 0; i < n; i++)
						load_key($urandom_range(0, 1) ? int'($urandom) : $urandom_range(0, 9), i == 0);
				end else if (kind <= 16) begin
					n = $urandom_range(1, 4);
					for (i = 0; i < n; i++)
						load_key(pick_target(), 1'b0);
				end
				run_queries($urandom_range(3, 16));
			end
			phase++;
		end

		calm = 0;
		drain_results();
		repeat (80) @(posedge clk);
		$display("Covered %0d phases: %0d loads (%0d dropped on a full table),", phase,
			sb.loads, sb.dropped);
		$display("%0d queries, %0d unused modes; largest table %0d keys; %0d results compared",
			sb.queries, sb.ignored, sb.peak, sb.checked);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
